FILE: src/tcr_pkg.sv
// shared types, constants and helper functions for the cell to rectangle block
package tcr_pkg;

  localparam logic [31:0] DefaultFg = 32'hFFE0E0E0;
  localparam logic [31:0] DefaultBg = 32'hFF101014;
  localparam int QueueDepth = 2;
  localparam int MaxCmds = 9;
  localparam int CmdIdxW = $clog2(MaxCmds + 1);

  typedef enum logic [0:0] {
    CFG_CELL_WIDTH  = 1'b0,
    CFG_CELL_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    SHAPE_RECT  = 1'b0,
    SHAPE_GLYPH = 1'b1
  } shape_t;

  typedef enum logic [3:0] {
    KIND_BLANK,
    KIND_FULL,
    KIND_UPPER,
    KIND_LOWER,
    KIND_LEFT_HALF,
    KIND_RIGHT_HALF,
    KIND_SHADE_LIGHT,
    KIND_SHADE_MED,
    KIND_SHADE_DARK,
    KIND_EIGHTHS,
    KIND_BOX,
    KIND_GLYPH
  } kind_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [31:0] fg_color;
    logic [31:0] bg_argb;
    logic        reverse_flag;
    logic        bold_flag;
    logic        invert_cursor;
    logic [11:0] cell_x;
    logic [11:0] cell_y;
  } cell_in_t;

  typedef struct packed {
    logic        shape_kind;
    logic [12:0] left;
    logic [12:0] top;
    logic [12:0] right;
    logic [12:0] bottom;
    logic [23:0] fill_rgb;
    logic [20:0] glyph_code;
    logic        last_item;
  } cmd_out_t;

  // classified cell handed from the front part to the back part
  typedef struct packed {
    kind_t       kind;
    logic [4:0]  box;
    logic [3:0]  eighths;
    logic        need_bg;
    logic [23:0] fg;
    logic [23:0] bg;
    logic [20:0] code_point;
    logic [11:0] x;
    logic [11:0] y;
  } job_t;

  function automatic logic [7:0] chan_scale(input logic [7:0] c, input logic [2:0] num,
                                            input logic [1:0] sh);
    logic [10:0] p;
    logic [10:0] v;
    begin
      p = 11'(c) * 11'(num);
      v = p >> sh;
      chan_scale = (v > 11'd255) ? 8'd255 : v[7:0];
    end
  endfunction

  function automatic logic [23:0] color_scale(input logic [23:0] c, input logic [2:0] num,
                                              input logic [1:0] sh);
    color_scale = {chan_scale(c[23:16], num, sh), chan_scale(c[15:8], num, sh),
                   chan_scale(c[7:0], num, sh)};
  endfunction

  // bit0 up, bit1 down, bit2 left, bit3 right, bit4 double
  function automatic logic [4:0] box_bits(input logic [20:0] cp);
    unique case (cp)
      21'h2500: box_bits = 5'h0C;
      21'h2502: box_bits = 5'h03;
      21'h250C: box_bits = 5'h09;
      21'h2510: box_bits = 5'h05;
      21'h2514: box_bits = 5'h0A;
      21'h2518: box_bits = 5'h06;
      21'h251C: box_bits = 5'h0B;
      21'h2524: box_bits = 5'h07;
      21'h252C: box_bits = 5'h0E;
      21'h2534: box_bits = 5'h0D;
      21'h253C: box_bits = 5'h0F;
      21'h2550: box_bits = 5'h1C;
      21'h2551: box_bits = 5'h13;
      21'h2554: box_bits = 5'h19;
      21'h2557: box_bits = 5'h15;
      21'h255A: box_bits = 5'h1A;
      21'h255D: box_bits = 5'h16;
      21'h2560: box_bits = 5'h1B;
      21'h2563: box_bits = 5'h17;
      21'h2566: box_bits = 5'h1E;
      21'h2569: box_bits = 5'h1D;
      21'h256C: box_bits = 5'h1F;
      default:  box_bits = 5'h00;
    endcase
  endfunction

endpackage

FILE: src/tcr_front.sv
// front part: resolves colors and classifies the cell into a job
module tcr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  tcr_pkg::cell_in_t cell_data,
  input  logic              pop,
  output logic              full,
  output logic              job_valid,
  output tcr_pkg::job_t     job
);

  tcr_pkg::job_t job_new;
  tcr_pkg::job_t slots [tcr_pkg::QueueDepth];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic [31:0]   fg_r;
  logic [31:0]   bg_r;
  logic [31:0]   fg_s;
  logic [31:0]   bg_s;
  logic          swapped;
  logic [20:0]   cp;

  always_comb begin
    cp = cell_data.code_point;
    fg_r = (cell_data.fg_color == '0) ? tcr_pkg::DefaultFg : cell_data.fg_color;
    bg_r = (cell_data.bg_argb == '0) ? tcr_pkg::DefaultBg : cell_data.bg_argb;
    swapped = cell_data.reverse_flag | cell_data.invert_cursor;
    fg_s = swapped ? bg_r : fg_r;
    bg_s = swapped ? fg_r : bg_r;
    job_new.need_bg = (bg_s != tcr_pkg::DefaultBg) | swapped;
    job_new.bg = bg_s[23:0];
    job_new.fg = cell_data.bold_flag ? tcr_pkg::color_scale(fg_s[23:0], 3'd5, 2'd2)
                                     : fg_s[23:0];
    job_new.code_point = cp;
    job_new.x = cell_data.cell_x;
    job_new.y = cell_data.cell_y;
    job_new.box = tcr_pkg::box_bits(cp);
    job_new.eighths = 4'(21'h258F - cp + 21'd1);
    if (cp == 21'd0 || cp == 21'd32) job_new.kind = tcr_pkg::KIND_BLANK;
    else if (cp == 21'h2588) job_new.kind = tcr_pkg::KIND_FULL;
    else if (cp == 21'h2580) job_new.kind = tcr_pkg::KIND_UPPER;
    else if (cp == 21'h2584) job_new.kind = tcr_pkg::KIND_LOWER;
    else if (cp == 21'h258C) job_new.kind = tcr_pkg::KIND_LEFT_HALF;
    else if (cp == 21'h2590) job_new.kind = tcr_pkg::KIND_RIGHT_HALF;
    else if (cp == 21'h2591) job_new.kind = tcr_pkg::KIND_SHADE_LIGHT;
    else if (cp == 21'h2592) job_new.kind = tcr_pkg::KIND_SHADE_MED;
    else if (cp == 21'h2593) job_new.kind = tcr_pkg::KIND_SHADE_DARK;
    else if (cp >= 21'h2589 && cp <= 21'h258F) job_new.kind = tcr_pkg::KIND_EIGHTHS;
    else if (cp >= 21'h2500 && cp <= 21'h256C) job_new.kind = tcr_pkg::KIND_BOX;
    else job_new.kind = tcr_pkg::KIND_GLYPH;
  end

  always_ff @(posedge clk) begin
    if (take) slots[wr_ptr] <= job_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (take) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(take) - 2'(pop);
    end
  end

  assign full      = (count == 2'(tcr_pkg::QueueDepth));
  assign job_valid = (count != '0);
  assign job       = slots[rd_ptr];

endmodule

FILE: src/tcr_back.sv
// back part: walks the command list of one job, one command per cycle
module tcr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [6:0]         cell_width,
  input  logic [6:0]         cell_height,
  input  logic               job_valid,
  input  tcr_pkg::job_t      job,
  output logic               pop,
  output logic               cmd_valid,
  output tcr_pkg::cmd_out_t  cmd
);

  // candidate command slots: bg, main, then 8 strokes
  logic [9:0]        cand_ok;
  tcr_pkg::cmd_out_t cand [10];
  tcr_pkg::cmd_out_t cmd_next;
  logic [3:0]        idx;
  logic [9:0]        remain;
  logic [3:0]        sel;
  logic              found;
  logic              more;

  logic signed [14:0] x0, y0, x1, y1, cx, cy, hx, hy, ex;
  logic [9:0]         ew_p;
  logic [6:0]         ew;
  logic [23:0]        fg;

  function automatic tcr_pkg::cmd_out_t mk(input logic signed [14:0] l, input logic signed [14:0] t,
                                           input logic signed [14:0] r,
                                           input logic signed [14:0] b, input logic [23:0] c);
    mk.shape_kind = tcr_pkg::SHAPE_RECT;
    mk.left = l[12:0];
    mk.top = t[12:0];
    mk.right = r[12:0];
    mk.bottom = b[12:0];
    mk.fill_rgb = c;
    mk.glyph_code = '0;
    mk.last_item = 1'b0;
  endfunction

  function automatic logic ok(input logic signed [14:0] l, input logic signed [14:0] t,
                              input logic signed [14:0] r, input logic signed [14:0] b);
    ok = (r >= l) && (b >= t);
  endfunction

  always_comb begin
    fg = job.fg;
    x0 = 15'(job.x);
    y0 = 15'(job.y);
    x1 = x0 + 15'(cell_width) - 15'sd1;
    y1 = y0 + 15'(cell_height) - 15'sd1;
    hx = x0 + 15'(cell_width >> 1);
    hy = y0 + 15'(cell_height >> 1);
    cx = hx;
    cy = hy;
    ew_p = 10'(cell_width) * 10'(job.eighths);
    ew = ew_p[9:3];
    ex = x0 + 15'(ew) - 15'sd1;
    for (int i = 0; i < 10; i++) begin
      cand[i] = mk(x0, y0, x1, y1, fg);
      cand_ok[i] = 1'b0;
    end
    cand[0] = mk(x0, y0, x1, y1, job.bg);
    cand_ok[0] = job.need_bg && ok(x0, y0, x1, y1);
    unique case (job.kind)
      tcr_pkg::KIND_BLANK: ;
      tcr_pkg::KIND_FULL: cand_ok[1] = ok(x0, y0, x1, y1);
      tcr_pkg::KIND_UPPER: begin
        cand[1] = mk(x0, y0, x1, hy - 15'sd1, fg);
        cand_ok[1] = ok(x0, y0, x1, hy - 15'sd1);
      end
      tcr_pkg::KIND_LOWER: begin
        cand[1] = mk(x0, hy, x1, y1, fg);
        cand_ok[1] = ok(x0, hy, x1, y1);
      end
      tcr_pkg::KIND_LEFT_HALF: begin
        cand[1] = mk(x0, y0, hx - 15'sd1, y1, fg);
        cand_ok[1] = ok(x0, y0, hx - 15'sd1, y1);
      end
      tcr_pkg::KIND_RIGHT_HALF: begin
        cand[1] = mk(hx, y0, x1, y1, fg);
        cand_ok[1] = ok(hx, y0, x1, y1);
      end
      tcr_pkg::KIND_SHADE_LIGHT: begin
        cand[1] = mk(x0, y0, x1, y1, tcr_pkg::color_scale(fg, 3'd1, 2'd2));
        cand_ok[1] = ok(x0, y0, x1, y1);
      end
      tcr_pkg::KIND_SHADE_MED: begin
        cand[1] = mk(x0, y0, x1, y1, tcr_pkg::color_scale(fg, 3'd1, 2'd1));
        cand_ok[1] = ok(x0, y0, x1, y1);
      end
      tcr_pkg::KIND_SHADE_DARK: begin
        cand[1] = mk(x0, y0, x1, y1, tcr_pkg::color_scale(fg, 3'd3, 2'd2));
        cand_ok[1] = ok(x0, y0, x1, y1);
      end
      tcr_pkg::KIND_EIGHTHS: begin
        cand[1] = mk(x0, y0, ex, y1, fg);
        cand_ok[1] = (ew != '0) && ok(x0, y0, ex, y1);
      end
      tcr_pkg::KIND_BOX: begin
        if (job.box[4]) begin
          cand[2] = mk(x0, cy - 15'sd2, cx, cy - 15'sd2, fg);
          cand[3] = mk(x0, cy + 15'sd1, cx, cy + 15'sd1, fg);
          cand[4] = mk(cx, cy - 15'sd2, x1, cy - 15'sd2, fg);
          cand[5] = mk(cx, cy + 15'sd1, x1, cy + 15'sd1, fg);
          cand[6] = mk(cx - 15'sd2, y0, cx - 15'sd2, cy, fg);
          cand[7] = mk(cx + 15'sd1, y0, cx + 15'sd1, cy, fg);
          cand[8] = mk(cx - 15'sd2, cy, cx - 15'sd2, y1, fg);
          cand[9] = mk(cx + 15'sd1, cy, cx + 15'sd1, y1, fg);
          cand_ok[2] = job.box[2] && ok(x0, cy, cx, cy);
          cand_ok[3] = cand_ok[2];
          cand_ok[4] = job.box[3] && ok(cx, cy, x1, cy);
          cand_ok[5] = cand_ok[4];
          cand_ok[6] = job.box[0] && ok(cx, y0, cx, cy);
          cand_ok[7] = cand_ok[6];
          cand_ok[8] = job.box[1] && ok(cx, cy, cx, y1);
          cand_ok[9] = cand_ok[8];
        end else begin
          cand[2] = mk(x0, cy - 15'sd1, cx, cy, fg);
          cand[4] = mk(cx, cy - 15'sd1, x1, cy, fg);
          cand[6] = mk(cx - 15'sd1, y0, cx, cy, fg);
          cand[8] = mk(cx - 15'sd1, cy, cx, y1, fg);
          cand_ok[2] = job.box[2] && ok(x0, cy, cx, cy);
          cand_ok[4] = job.box[3] && ok(cx, cy, x1, cy);
          cand_ok[6] = job.box[0] && ok(cx, y0, cx, cy);
          cand_ok[8] = job.box[1] && ok(cx, cy, cx, y1);
        end
      end
      tcr_pkg::KIND_GLYPH: begin
        cand[1].shape_kind = tcr_pkg::SHAPE_GLYPH;
        cand[1].left = 13'(job.x);
        cand[1].top = 13'(job.y);
        cand[1].right = '0;
        cand[1].bottom = '0;
        cand[1].glyph_code = job.code_point;
        cand_ok[1] = 1'b1;
      end
      default: ;
    endcase
  end

  // pick first pending slot at or after idx
  always_comb begin
    remain = '0;
    for (int i = 0; i < 10; i++) remain[i] = cand_ok[i] && (4'(i) >= idx);
    sel = '0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (remain[i]) begin
        sel = 4'(i);
        found = 1'b1;
      end
    end
    more = 1'b0;
    for (int i = 0; i < 10; i++) if (remain[i] && 4'(i) > sel) more = 1'b1;
    pop = job_valid && !more;
    cmd_next = cand[sel];
    cmd_next.last_item = !more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= job_valid && found;
      if (job_valid) idx <= more ? sel + 4'd1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
  end

endmodule

FILE: src/terminal_cell_to_rect_commands.sv
// top level: terminal cell to draw command converter
// usage:
//   cells enter on start/cell_data, taken at an edge where start is high and busy low.
//   commands leave on cmd with cmd_valid high for one cycle each; the receiver
//   cannot stall, so every command is a transfer in the cycle it is shown.
//   last_item marks the final command of a cell; a blank cell on the default
//   background gives no command at all.
//   a front stage resolves colors and classifies the cell into a two-entry
//   job queue; the back stage sends one command per cycle from the head job.
//   a cell gives up to 9 commands, all sent by the single command output of the
//   back stage, which registers each command before it is shown on cmd.
//   busy rises when the job queue is full.
//   reset (rst, synchronous) empties the queue and sets cell size to 8 by 9.
//   cfg_we/cfg_index/cfg_data write cell_width (0) and cell_height (1) while idle;
//   the user must keep to this, as the block itself leaves it unchecked.
module terminal_cell_to_rect_commands (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcr_pkg::cell_in_t cell_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data,
  output logic              cmd_valid,
  output tcr_pkg::cmd_out_t cmd
);

  logic [6:0]    cell_width;
  logic [6:0]    cell_height;
  logic          take;
  logic          pop;
  logic          job_valid;
  tcr_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width  <= 7'd8;
      cell_height <= 7'd9;
    end else if (cfg_we) begin
      unique case (tcr_pkg::cfg_index_t'(cfg_index))
        tcr_pkg::CFG_CELL_WIDTH:  cell_width  <= cfg_data;
        tcr_pkg::CFG_CELL_HEIGHT: cell_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign take = start && !busy;

  tcr_front u_front (
    .clk(clk), .rst(rst), .take(take), .cell_data(cell_data), .pop(pop),
    .full(busy), .job_valid(job_valid), .job(job)
  );

  tcr_back u_back (
    .clk(clk), .rst(rst), .cell_width(cell_width), .cell_height(cell_height),
    .job_valid(job_valid), .job(job), .pop(pop), .cmd_valid(cmd_valid), .cmd(cmd)
  );

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst) pop |-> job_valid)
    else $error("job popped from empty queue");
  a_no_cmd_after_reset: assert property (@(posedge clk) rst |=> !cmd_valid)
    else $error("command after reset");
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (busy && !pop) |=> busy)
    else $error("queue drained without pop");

endmodule

FILE: dv/terminal_cell_to_rect_commands_tb.sv
// testbench for the terminal cell to draw command converter
`timescale 1ns / 1ps

module terminal_cell_to_rect_commands_tb;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  tcr_pkg::cell_in_t cell_data;
  logic              cfg_we;
  logic              cfg_index;
  logic [6:0]        cfg_data;
  logic              cmd_valid;
  tcr_pkg::cmd_out_t cmd;

  terminal_cell_to_rect_commands i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cell_data(cell_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd(cmd)
  );

  tcr_pkg::cell_in_t pending_cells[$];
  tcr_pkg::cmd_out_t expected_cmds[$];
  int       cur_width;
  int       cur_height;
  int       mismatches;
  int       stall_cycles;
  bit       allow_gaps;
  int       gap_left;
  logic     taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // 5/4, 1/4, 1/2, 3/4 channel scaling with saturation
  function automatic logic [7:0] scale_chan(logic [7:0] c, int num, int den);
    int v;
    v = int'(c) * num / den;
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic logic [23:0] scale_rgb(logic [23:0] c, int num, int den);
    return {scale_chan(c[23:16], num, den), scale_chan(c[15:8], num, den),
            scale_chan(c[7:0], num, den)};
  endfunction

  function automatic logic [4:0] stroke_mask(logic [20:0] cp);
    case (cp)
      21'h2500: return 5'h0C; 21'h2502: return 5'h03; 21'h250C: return 5'h09;
      21'h2510: return 5'h05; 21'h2514: return 5'h0A; 21'h2518: return 5'h06;
      21'h251C: return 5'h0B; 21'h2524: return 5'h07; 21'h252C: return 5'h0E;
      21'h2534: return 5'h0D; 21'h253C: return 5'h0F; 21'h2550: return 5'h1C;
      21'h2551: return 5'h13; 21'h2554: return 5'h19; 21'h2557: return 5'h15;
      21'h255A: return 5'h1A; 21'h255D: return 5'h16; 21'h2560: return 5'h1B;
      21'h2563: return 5'h17; 21'h2566: return 5'h1E; 21'h2569: return 5'h1D;
      21'h256C: return 5'h1F;
      default:  return 5'h00;
    endcase
  endfunction

  function automatic void push_cmd(ref tcr_pkg::cmd_out_t q[$], input tcr_pkg::shape_t k,
                                   input int l, t, r, b,
                                   input logic [23:0] rgb, input logic [20:0] code);
    tcr_pkg::cmd_out_t c;
    c.shape_kind = k;
    c.left = 13'(l);
    c.top = 13'(t);
    c.right = 13'(r);
    c.bottom = 13'(b);
    c.fill_rgb = rgb;
    c.glyph_code = code;
    c.last_item = 1'b0;
    q.push_back(c);
  endfunction

  function automatic void push_rect(ref tcr_pkg::cmd_out_t q[$], input int l, t, r, b,
                                    input logic [23:0] rgb);
    if (r >= l && b >= t) push_cmd(q, tcr_pkg::SHAPE_RECT, l, t, r, b, rgb, 21'd0);
  endfunction

  task automatic predict_commands(input tcr_pkg::cell_in_t ci);
    tcr_pkg::cmd_out_t q[$];
    logic [31:0] fg, bg, tmp;
    logic [20:0] cp;
    logic [4:0] s;
    int x, y, w, h, x1, y1, cx, cy, ew;
    bit swapped;
    cp = ci.code_point;
    fg = (ci.fg_color == 0) ? tcr_pkg::DefaultFg : ci.fg_color;
    bg = (ci.bg_argb == 0) ? tcr_pkg::DefaultBg : ci.bg_argb;
    swapped = ci.reverse_flag || ci.invert_cursor;
    if (swapped) begin
      tmp = fg; fg = bg; bg = tmp;
    end
    if (ci.bold_flag) fg = {8'hFF, scale_rgb(fg[23:0], 5, 4)};
    x = ci.cell_x; y = ci.cell_y; w = cur_width; h = cur_height;
    x1 = x + w - 1; y1 = y + h - 1; cx = x + w / 2; cy = y + h / 2;
    if (bg != tcr_pkg::DefaultBg || swapped) push_rect(q, x, y, x1, y1, bg[23:0]);
    if (cp == 0 || cp == 32) begin
    end else if (cp == 21'h2588) begin
      push_rect(q, x, y, x1, y1, fg[23:0]);
    end else if (cp == 21'h2580) begin
      push_rect(q, x, y, x1, y + h / 2 - 1, fg[23:0]);
    end else if (cp == 21'h2584) begin
      push_rect(q, x, y + h / 2, x1, y1, fg[23:0]);
    end else if (cp == 21'h258C) begin
      push_rect(q, x, y, x + w / 2 - 1, y1, fg[23:0]);
    end else if (cp == 21'h2590) begin
      push_rect(q, x + w / 2, y, x1, y1, fg[23:0]);
    end else if (cp == 21'h2591) begin
      push_rect(q, x, y, x1, y1, scale_rgb(fg[23:0], 1, 4));
    end else if (cp == 21'h2592) begin
      push_rect(q, x, y, x1, y1, scale_rgb(fg[23:0], 1, 2));
    end else if (cp == 21'h2593) begin
      push_rect(q, x, y, x1, y1, scale_rgb(fg[23:0], 3, 4));
    end else if (cp >= 21'h2589 && cp <= 21'h258F) begin
      ew = w * (int'(21'h258F - cp) + 1) / 8;
      if (ew > 0) push_rect(q, x, y, x + ew - 1, y1, fg[23:0]);
    end else if (cp >= 21'h2500 && cp <= 21'h256C) begin
      s = stroke_mask(cp);
      if (s[4]) begin
        if (s[2]) begin
          push_rect(q, x, cy - 2, cx, cy - 2, fg[23:0]);
          push_rect(q, x, cy + 1, cx, cy + 1, fg[23:0]);
        end
        if (s[3]) begin
          push_rect(q, cx, cy - 2, x1, cy - 2, fg[23:0]);
          push_rect(q, cx, cy + 1, x1, cy + 1, fg[23:0]);
        end
        if (s[0]) begin
          push_rect(q, cx - 2, y, cx - 2, cy, fg[23:0]);
          push_rect(q, cx + 1, y, cx + 1, cy, fg[23:0]);
        end
        if (s[1]) begin
          push_rect(q, cx - 2, cy, cx - 2, y1, fg[23:0]);
          push_rect(q, cx + 1, cy, cx + 1, y1, fg[23:0]);
        end
      end else begin
        if (s[2]) push_rect(q, x, cy - 1, cx, cy, fg[23:0]);
        if (s[3]) push_rect(q, cx, cy - 1, x1, cy, fg[23:0]);
        if (s[0]) push_rect(q, cx - 1, y, cx, cy, fg[23:0]);
        if (s[1]) push_rect(q, cx - 1, cy, cx, y1, fg[23:0]);
      end
    end else begin
      push_cmd(q, tcr_pkg::SHAPE_GLYPH, x, y, 0, 0, fg[23:0], cp);
    end
    if (q.size() > 0) q[q.size() - 1].last_item = 1'b1;
    foreach (q[i]) expected_cmds.push_back(q[i]);
  endtask

  // a cell shown with start high and busy low at the rising edge is a transfer
  always @(posedge clk) begin
    taken <= start && !busy && !rst;
    if (start && !busy && !rst) predict_commands(cell_data);
  end

  // driver: one cell per transfer, random gap bursts while allowed
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (taken || !start) begin
      if (taken) void'(pending_cells.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (allow_gaps && taken && $urandom_range(0, 4) == 0) begin
        gap_left <= $urandom_range(1, 9) - 1;
        start <= 1'b0;
      end else if (pending_cells.size() > 0) begin
        start <= 1'b1;
        cell_data <= pending_cells[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tcr_pkg::cmd_out_t want;
    if (!rst && cmd_valid) begin
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected command %p", cmd);
      end else begin
        want = expected_cmds.pop_front();
        if (cmd !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("command mismatch: expected %p, got %p", want, cmd);
        end
      end
    end
  end

  // watchdog on cycles with no transfer of either kind
  always @(posedge clk) begin
    if (rst || cmd_valid || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  task automatic wait_drained();
    while (pending_cells.size() > 0 || start || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input tcr_pkg::cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 7'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == tcr_pkg::CFG_CELL_WIDTH) cur_width = value;
    else cur_height = value;
  endtask

  function automatic logic [20:0] pick_code();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1)) ? 21'd0 : 21'd32;
      1, 2, 3: return 21'h2500 + 21'($urandom_range(0, 16'h6C));
      4, 5: return 21'h2580 + 21'($urandom_range(0, 16'h13));
      6: return 21'($urandom_range(0, 21'h10FFFF));
      default: return 21'($urandom_range(33, 16'h7E));
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return tcr_pkg::DefaultBg;
      2: return tcr_pkg::DefaultFg;
      default: return $urandom;
    endcase
  endfunction

  function automatic tcr_pkg::cell_in_t random_cell();
    tcr_pkg::cell_in_t c;
    c.code_point = pick_code();
    c.fg_color = pick_color();
    c.bg_argb = pick_color();
    c.reverse_flag = $urandom_range(0, 3) == 0;
    c.bold_flag = 1'($urandom_range(0, 1));
    c.invert_cursor = $urandom_range(0, 5) == 0;
    c.cell_x = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom_range(0, 4032));
    c.cell_y = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom_range(0, 4032));
    return c;
  endfunction

  function automatic tcr_pkg::cell_in_t make_cell(logic [20:0] cp, logic [31:0] fg, bg,
                                                  logic r, b, i, logic [11:0] x, y);
    tcr_pkg::cell_in_t c;
    c = '{cp, fg, bg, r, b, i, x, y};
    return c;
  endfunction

  initial begin
    logic [20:0] directed_codes[19];
    int sizes[4][2];
    directed_codes = '{21'd0, 21'd32, 21'h2588, 21'h2580, 21'h2584,
      21'h258C, 21'h2590, 21'h2591, 21'h2592, 21'h2593, 21'h2589, 21'h258F,
      21'h2500, 21'h253C, 21'h256C, 21'h2550, 21'h2501, 21'h10FFFF, 21'h41};
    sizes = '{'{1, 1}, '{64, 64}, '{3, 2}, '{127, 0}};
    rst = 1'b1; cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    cur_width = 8; cur_height = 9;
    allow_gaps = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed cells at reset size
    foreach (directed_codes[i])
      pending_cells.push_back(make_cell(directed_codes[i], (i % 2) ? 32'h0 : 32'hFFFFFFFF,
        (i % 3) ? 32'h0 : 32'hFFFFFFFF, i % 4 == 1, i % 2 == 1, i % 5 == 2,
        (i % 2) ? 12'd0 : 12'd4032, (i % 2) ? 12'hFFF : 12'd0));
    pending_cells.push_back(make_cell(21'h41, 32'hFF808080, 32'hFF101014, 1'b0, 1'b1, 1'b0,
                                      12'd0, 12'd0));
    pending_cells.push_back(make_cell(21'h2593, tcr_pkg::DefaultFg, 32'h00101014, 1'b1, 1'b1,
                                      1'b1, 12'd12, 12'd12));
    wait_drained();

    // random cells across several cell sizes; sender pauses until drained per phase
    foreach (sizes[k]) begin
      write_reg(tcr_pkg::CFG_CELL_WIDTH, sizes[k][0]);
      write_reg(tcr_pkg::CFG_CELL_HEIGHT, sizes[k][1]);
      repeat (15) pending_cells.push_back(random_cell());
      wait_drained();
    end
    write_reg(tcr_pkg::CFG_CELL_WIDTH, 8);
    write_reg(tcr_pkg::CFG_CELL_HEIGHT, 9);
    repeat (80) pending_cells.push_back(random_cell());
    wait_drained();
    allow_gaps = 1'b0;
    write_reg(tcr_pkg::CFG_CELL_WIDTH, $urandom_range(1, 64));
    write_reg(tcr_pkg::CFG_CELL_HEIGHT, $urandom_range(1, 64));
    repeat (20) pending_cells.push_back(random_cell());
    wait_drained();

    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("terminal_cell_to_rect_commands verification clean");
    end else begin
      $display("terminal_cell_to_rect_commands verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (stall_cycles > 2000) begin
      $display("terminal_cell_to_rect_commands verification failed");
      $finish;
    end
  end

endmodule

FILE: filelist.f
src/tcr_pkg.sv
src/tcr_front.sv
src/tcr_back.sv
src/terminal_cell_to_rect_commands.sv
dv/terminal_cell_to_rect_commands_tb.sv
